// ===== hdl/asa_pkg.sv =====
// Shared types, constants and the arctangent step table for the arc sweep angle block.
`timescale 1ns / 1ps

package asa_pkg;

  // Prescaled vector width: magnitudes reach 2^60 times the CORDIC gain.
  localparam int XY_W = 63;
  // Accumulated angle, signed, with headroom over the table sum.
  localparam int Z_W = 25;
  // Point angle, unsigned, [0, 360) degrees.
  localparam int ANG_W = 25;
  // Sweep, signed, [-360, 360] degrees.
  localparam int SWP_W = 26;
  // Register tolerances.
  localparam int TOL_W = 16;
  // Operands are normalised to this bit position.
  localparam int PRESCALE_TOP = 60;
  // Declared arctangent table depth; atan_step holds entries 0 to 22 and gives zero beyond.
  localparam int ATAN_DEPTH = 32;

  // Angle units: 1/65536 degree.
  localparam int DEG_UNIT = 65536;
  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * DEG_UNIT);
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(180 * DEG_UNIT);
  localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(360 * DEG_UNIT);

  // Configuration register indexes.
  localparam logic REG_ANGLE_TOL = 1'b0;
  localparam logic REG_COORD_TOL = 1'b1;

  // One vector in flight through the CORDIC row.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } vec_t;

  // Per-item flags carried alongside the vectors.
  typedef struct packed {
    logic cw;
    logic deg;
    logic s_nonneg;
    logic e_nonneg;
    logic s_negx;
    logic e_negx;
  } side_t;

  // Request travelling through the CORDIC row.
  typedef struct packed {
    vec_t s;
    vec_t e;
    side_t side;
  } pkt_t;

  // Point angles ready for the sweep stage.
  typedef struct packed {
    logic [ANG_W-1:0] sa;
    logic [ANG_W-1:0] ea;
    logic cw;
    logic deg;
  } res_t;

  // atan(2^-i) in 1/65536 degree.
  function automatic logic signed [Z_W-1:0] atan_step(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/asa_prep.sv =====
// Front end: centre offsets, magnitudes, prescaling and per-point flags.
`timescale 1ns / 1ps

module asa_prep import asa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [TOL_W-1:0]              coord_tol,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] sx,
  input  logic signed [COORD_WIDTH-1:0] sy,
  input  logic signed [COORD_WIDTH-1:0] ex,
  input  logic signed [COORD_WIDTH-1:0] ey,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic                          cw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pkt_t                          out_pkt
);

  localparam int D_W = COORD_WIDTH + 1;
  localparam int PRESCALE = PRESCALE_TOP - COORD_WIDTH;

  // First stage: offsets from the centre
  logic                  a_valid_r;
  logic                  a_ready;
  logic signed [D_W-1:0] sdx_r, sdy_r, edx_r, edy_r;
  logic                  cw_r;

  // Second stage: packet register
  logic b_valid_r;
  pkt_t pkt_r;
  pkt_t pkt_nxt;

  assign in_ready  = !a_valid_r || a_ready;
  assign a_ready   = !b_valid_r || out_ready;
  assign out_valid = b_valid_r;
  assign out_pkt   = pkt_r;

  // Widen by one bit so the difference never wraps
  function automatic logic signed [D_W-1:0] diff(input logic signed [COORD_WIDTH-1:0] p,
                                                 input logic signed [COORD_WIDTH-1:0] c);
    return {p[COORD_WIDTH-1], p} - {c[COORD_WIDTH-1], c};
  endfunction

  // Magnitude placed at the normalised bit position
  function automatic logic signed [XY_W-1:0] scaled_mag(input logic signed [D_W-1:0] d);
    logic [D_W-1:0]  mag;
    logic [XY_W-1:0] wide;
    mag  = d[D_W-1] ? D_W'(-d) : d;
    wide = {{(XY_W-D_W){1'b0}}, mag} << PRESCALE;
    return $signed(wide);
  endfunction

  // dy counts as non-negative when dy + tolerance is not below zero
  function automatic logic nonneg(input logic signed [D_W-1:0] d,
                                  input logic [TOL_W-1:0] tol);
    logic signed [D_W:0] t;
    t = {d[D_W-1], d} + $signed({{(D_W+1-TOL_W){1'b0}}, tol});
    return !t[D_W];
  endfunction

  always_comb begin
    pkt_nxt.s.x           = scaled_mag(sdx_r);
    pkt_nxt.s.y           = scaled_mag(sdy_r);
    pkt_nxt.s.z           = '0;
    pkt_nxt.e.x           = scaled_mag(edx_r);
    pkt_nxt.e.y           = scaled_mag(edy_r);
    pkt_nxt.e.z           = '0;
    pkt_nxt.side.cw       = cw_r;
    pkt_nxt.side.deg      = ((sdx_r == '0) && (sdy_r == '0)) ||
                            ((edx_r == '0) && (edy_r == '0));
    pkt_nxt.side.s_nonneg = nonneg(sdy_r, coord_tol);
    pkt_nxt.side.e_nonneg = nonneg(edy_r, coord_tol);
    pkt_nxt.side.s_negx   = sdx_r[D_W-1];
    pkt_nxt.side.e_negx   = edx_r[D_W-1];
  end

  // Advance the offset stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      sdx_r <= diff(sx, cx);
      sdy_r <= diff(sy, cy);
      edx_r <= diff(ex, cx);
      edy_r <= diff(ey, cy);
      cw_r  <= cw;
    end
  end

  // Advance the packet stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
    if (a_valid_r && a_ready) begin
      pkt_r <= pkt_nxt;
    end
  end

endmodule

// ===== hdl/asa_cell.sv =====
// One CORDIC vectoring iteration for both points of a request.
`timescale 1ns / 1ps

module asa_cell import asa_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pkt_t in_pkt,
  output logic out_valid,
  input  logic out_ready,
  output pkt_t out_pkt
);

  localparam logic signed [Z_W-1:0] ATAN = atan_step(STAGE);

  logic valid_r;
  pkt_t pkt_r;
  pkt_t pkt_nxt;

  // Rotate toward the x axis by the sign of y; hold when y is zero
  function automatic vec_t rotate(input vec_t v);
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    vec_t r;
    xs = v.x >>> STAGE;
    ys = v.y >>> STAGE;
    r  = v;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ATAN;
    end else if (v.y < 0) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ATAN;
    end
    return r;
  endfunction

  always_comb begin
    pkt_nxt      = in_pkt;
    pkt_nxt.s    = rotate(in_pkt.s);
    pkt_nxt.e    = rotate(in_pkt.e);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;

  // Hand the request on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      pkt_r <= pkt_nxt;
    end
  end

endmodule

// ===== hdl/asa_finish.sv =====
// Back end: clamp the CORDIC angle, unfold the half plane and form point angles.
`timescale 1ns / 1ps

module asa_finish import asa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOL_W-1:0] angle_tol,
  input  logic             in_valid,
  output logic             in_ready,
  input  pkt_t             in_pkt,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);

  logic valid_r;
  res_t res_r;
  res_t res_nxt;

  // Clockwise angle from +x for one point
  function automatic logic [ANG_W-1:0] point_angle(input logic signed [Z_W-1:0] z,
                                                   input logic negx,
                                                   input logic nonneg,
                                                   input logic [TOL_W-1:0] tol);
    logic [ANG_W-1:0] zc;
    logic [ANG_W-1:0] a;
    logic [ANG_W-1:0] r;
    if (z < 0) begin
      zc = '0;
    end else if ($unsigned(z) > QUARTER_TURN) begin
      zc = QUARTER_TURN;
    end else begin
      zc = $unsigned(z);
    end
    a = negx ? (HALF_TURN - zc) : zc;
    if (!nonneg) begin
      r = a;
    end else if (a <= {{(ANG_W-TOL_W){1'b0}}, tol}) begin
      r = '0;
    end else begin
      r = FULL_TURN - a;
    end
    return r;
  endfunction

  always_comb begin
    res_nxt.sa  = point_angle(in_pkt.s.z, in_pkt.side.s_negx, in_pkt.side.s_nonneg,
                              angle_tol);
    res_nxt.ea  = point_angle(in_pkt.e.z, in_pkt.side.e_negx, in_pkt.side.e_nonneg,
                              angle_tol);
    res_nxt.cw  = in_pkt.side.cw;
    res_nxt.deg = in_pkt.side.deg;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== hdl/arc_sweep_angle.sv =====
// Arc sweep angle: start and end angles about a centre and the signed sweep.
// Pipeline: two front stages, one cell per CORDIC iteration, the angle stage and the
// sweep output register. Throughput: one request per cycle while out_tready is high;
// every stage is a register slice with its own ready.
// Reset (synchronous, rst_n low) empties every stage and sets angle_tolerance to 1 and
// coord_tolerance to 0.
`timescale 1ns / 1ps

module arc_sweep_angle import asa_pkg::*; #(
  parameter int CORDIC_STAGES = 24,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // start_x, start_y, end_x, end_y, center_x, center_y (COORD_WIDTH each), zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]         in_tdata,
  // clockwise
  input  logic                                      in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // start bearing [24:0], end bearing [49:25], sweep [75:50], zero pad
  output logic [79:0]                               out_tdata,
  // degenerate
  output logic                                      out_tuser,
  input  logic                                      cfg_psel,
  input  logic                                      cfg_penable,
  input  logic                                      cfg_pwrite,
  input  logic [2:0]                                cfg_paddr,
  input  logic [31:0]                               cfg_pwdata,
  output logic [31:0]                               cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int CW     = COORD_WIDTH;
  localparam int SEXT_W = SWP_W + 1;

  // Configuration registers
  logic [TOL_W-1:0] angle_tol_r;
  logic [TOL_W-1:0] coord_tol_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_tol_r <= TOL_W'(1);
      coord_tol_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ANGLE_TOL: angle_tol_r <= cfg_pwdata[TOL_W-1:0];
        REG_COORD_TOL: coord_tol_r <= cfg_pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_paddr[2])
      REG_ANGLE_TOL: cfg_prdata = {{(32-TOL_W){1'b0}}, angle_tol_r};
      REG_COORD_TOL: cfg_prdata = {{(32-TOL_W){1'b0}}, coord_tol_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Front end
  logic [CORDIC_STAGES:0] chain_valid;
  logic [CORDIC_STAGES:0] chain_ready;
  pkt_t                   chain_pkt [CORDIC_STAGES+1];

  asa_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .coord_tol(coord_tol_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sx       ($signed(in_tdata[0*CW +: CW])),
    .sy       ($signed(in_tdata[1*CW +: CW])),
    .ex       ($signed(in_tdata[2*CW +: CW])),
    .ey       ($signed(in_tdata[3*CW +: CW])),
    .cx       ($signed(in_tdata[4*CW +: CW])),
    .cy       ($signed(in_tdata[5*CW +: CW])),
    .cw       (in_tuser),
    .out_valid(chain_valid[0]),
    .out_ready(chain_ready[0]),
    .out_pkt  (chain_pkt[0])
  );

  // Row of CORDIC cells, one iteration each
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    asa_cell #(
      .STAGE(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (chain_valid[g]),
      .in_ready (chain_ready[g]),
      .in_pkt   (chain_pkt[g]),
      .out_valid(chain_valid[g+1]),
      .out_ready(chain_ready[g+1]),
      .out_pkt  (chain_pkt[g+1])
    );
  end

  // Point angles
  logic fin_valid;
  logic fin_ready;
  res_t fin_res;

  asa_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .angle_tol(angle_tol_r),
    .in_valid (chain_valid[CORDIC_STAGES]),
    .in_ready (chain_ready[CORDIC_STAGES]),
    .in_pkt   (chain_pkt[CORDIC_STAGES]),
    .out_valid(fin_valid),
    .out_ready(fin_ready),
    .out_res  (fin_res)
  );

  // Sweep: difference, wrap by a full turn, saturate, zero for a degenerate request
  logic signed [SEXT_W-1:0] diff_s;
  logic signed [SEXT_W-1:0] tol_s;
  logic signed [SEXT_W-1:0] full_s;
  logic signed [SEXT_W-1:0] wrap_s;
  logic signed [SEXT_W-1:0] sat_s;
  logic [SWP_W-1:0]         sweep_nxt;

  always_comb begin
    diff_s = $signed({{(SEXT_W-ANG_W){1'b0}}, fin_res.ea}) -
             $signed({{(SEXT_W-ANG_W){1'b0}}, fin_res.sa});
    tol_s  = $signed({{(SEXT_W-TOL_W){1'b0}}, angle_tol_r});
    full_s = $signed({{(SEXT_W-ANG_W){1'b0}}, FULL_TURN});
    wrap_s = diff_s;
    if (fin_res.cw) begin
      if (diff_s <= tol_s) wrap_s = diff_s + full_s;
    end else begin
      if (diff_s >= -tol_s) wrap_s = diff_s - full_s;
    end
    if (wrap_s > full_s) begin
      sat_s = full_s;
    end else if (wrap_s < -full_s) begin
      sat_s = -full_s;
    end else begin
      sat_s = wrap_s;
    end
    sweep_nxt = fin_res.deg ? '0 : sat_s[SWP_W-1:0];
  end

  // Output register
  logic             out_valid_r;
  logic [ANG_W-1:0] sa_r;
  logic [ANG_W-1:0] ea_r;
  logic [SWP_W-1:0] sweep_r;
  logic             deg_r;

  assign fin_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= fin_valid;
    end
    if (fin_valid && fin_ready) begin
      sa_r    <= fin_res.sa;
      ea_r    <= fin_res.ea;
      sweep_r <= sweep_nxt;
      deg_r   <= fin_res.deg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(80-2*ANG_W-SWP_W){1'b0}}, sweep_r, ea_r, sa_r};
  assign out_tuser  = deg_r;

  // A degenerate result, and only that, carries a zero sweep
  a_deg_zero_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[75:50] == '0)))
    else $error("degenerate flag and zero sweep disagree");

  // Point angles stay below a full turn
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[24:0] < FULL_TURN) && (out_tdata[49:25] < FULL_TURN)))
    else $error("point angle out of range");

  // The sweep never exceeds one full turn either way
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[75:50]) <= $signed({1'b0, FULL_TURN})) &&
                    ($signed(out_tdata[75:50]) >= -$signed({1'b0, FULL_TURN}))))
    else $error("sweep out of range");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule
